// ===== hdl/bcpof_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color pair offset features: shared package
// Request codes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package bcpof_pkg;

  // Request codes carried in req_type.
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_t;

  // Field widths of the request and response channels.
  localparam int REQ_TYPE_W = 2;
  localparam int PIXEL_W    = 8;
  localparam int COLOR_W    = 7;
  localparam int OFFSET_W   = 5;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_HEIGHT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_WIDTH  = 1'd1;
  localparam logic [CFG_DATA_W-1:0]  BLOCK_HEIGHT_RESET = 8'd15;
  localparam logic [CFG_DATA_W-1:0]  BLOCK_WIDTH_RESET  = 8'd10;

  // Dividend and divisor width of the grid divider; covers screens up to
  // 512 pixels and block sizes up to 512.
  localparam int DIV_W = 10;

endpackage

// ===== hdl/bcpof_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color pair offset features: channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcpof_req_if import bcpof_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [PIXEL_W-1:0]    pixel_row;
  logic [PIXEL_W-1:0]    pixel_col;
  logic [COLOR_W-1:0]    pixel_color;
  logic [COLOR_W-1:0]    query_color_low;
  logic [COLOR_W-1:0]    query_color_high;
  logic [OFFSET_W-1:0]   row_offset;
  logic [OFFSET_W-1:0]   col_offset;

  modport source (output valid, req_type, pixel_row, pixel_col, pixel_color,
                  query_color_low, query_color_high, row_offset, col_offset,
                  input ready);
  modport sink   (input valid, req_type, pixel_row, pixel_col, pixel_color,
                  query_color_low, query_color_high, row_offset, col_offset,
                  output ready);
endinterface

interface bcpof_rsp_if;
  logic valid;
  logic ready;
  logic feature_present;
  logic new_basic;

  modport source (output valid, feature_present, new_basic, input ready);
  modport sink   (input valid, feature_present, new_basic, output ready);
endinterface

interface bcpof_cfg_if import bcpof_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/bcpof_grid_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color pair offset features: grid divider
// Four lanes of repeated subtraction, one step per cycle, giving block
// coordinates and grid sizes from pixel positions and block sizes.
// ----------------------------------------------------------------------------
module bcpof_grid_div import bcpof_pkg::*; #(
  parameter int QW = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend [4],
  input  logic [DIV_W-1:0] divisor  [4],
  output logic [QW-1:0]    quot     [4],
  output logic             done
);

  logic             busy;
  logic [DIV_W-1:0] rem [4];
  logic [DIV_W-1:0] dsr [4];
  logic [3:0]       lane_fin;

  // A lane is finished once its remainder drops below the divisor.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane_fin[i] = rem[i] < dsr[i];
    end
  end

  assign done = busy && (&lane_fin);

  // Control: busy from start until all lanes are finished.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  // Datapath: load on start, then subtract once per cycle where possible.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (start) begin
        rem[i]  <= dividend[i];
        dsr[i]  <= divisor[i];
        quot[i] <= '0;
      end else if (busy && !lane_fin[i]) begin
        rem[i]  <= rem[i] - dsr[i];
        quot[i] <= quot[i] + QW'(1);
      end
    end
  end

endmodule

// ===== hdl/block_color_pair_offset_features_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color pair offset features: top level
// Basic color-in-block presence and pairwise relative offset presence,
// kept in two synchronous memories.
// ----------------------------------------------------------------------------
// One request is processed at a time. A pixel or query request first runs the
// grid divider, one subtraction per cycle, then reads memory; a pixel that
// adds no new feature finishes there. A pixel that adds a new feature then
// walks every word of the basic memory (COLORS * MAX_GRID_ROWS words): each
// word is read and paired with the new feature, and a word holding matching
// features adds a read, modify and write of one offset memory word. A clear
// request, and reset, sweeps both memories one word per cycle; no request is
// taken during the sweep, configuration writes are. The response register
// lets the next request enter while a response waits.
// ----------------------------------------------------------------------------
module block_color_pair_offset_features_top import bcpof_pkg::*; #(
  parameter int COLORS        = 128,
  parameter int SCREEN_ROWS   = 210,
  parameter int SCREEN_COLS   = 160,
  parameter int MAX_GRID_ROWS = 14,
  parameter int MAX_GRID_COLS = 16
) (
  input logic       clk,
  input logic       rst,
  bcpof_req_if.sink   req,
  bcpof_rsp_if.source rsp,
  bcpof_cfg_if.sink   cfg
);

  localparam int ROW_SPAN    = 2 * MAX_GRID_ROWS - 1;
  localparam int COL_SPAN    = 2 * MAX_GRID_COLS - 1;
  localparam int PAIR_COUNT  = COLORS * (COLORS + 1) / 2;
  localparam int BASIC_DEPTH = COLORS * MAX_GRID_ROWS;
  localparam int OFF_DEPTH   = PAIR_COUNT * ROW_SPAN;
  localparam int CLR_DEPTH   = (OFF_DEPTH > BASIC_DEPTH) ? OFF_DEPTH : BASIC_DEPTH;
  localparam int MIN_BH      = (SCREEN_ROWS + MAX_GRID_ROWS - 1) / MAX_GRID_ROWS;
  localparam int MIN_BW      = (SCREEN_COLS + MAX_GRID_COLS - 1) / MAX_GRID_COLS;
  localparam int CW          = $clog2(COLORS);
  localparam int RW          = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
  localparam int KW          = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
  localparam int QW          = (RW > KW) ? RW : KW;
  localparam int DW          = QW + 3;
  localparam int EW          = QW + 6;
  localparam int BA_W        = $clog2(BASIC_DEPTH);
  localparam int OA_W        = $clog2(OFF_DEPTH);
  localparam int CLR_W       = $clog2(CLR_DEPTH);
  localparam int RO_W        = (ROW_SPAN > 1) ? $clog2(ROW_SPAN) : 1;
  localparam int CO_W        = (COL_SPAN > 1) ? $clog2(COL_SPAN) : 1;
  localparam int PM_W        = $clog2(2 * COLORS + 2);
  localparam int PW          = CW + PM_W;
  localparam int PI_W        = $clog2(PAIR_COUNT);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_PIX_RD, S_PIX_CHK, S_WALK_RD, S_WALK_CALC,
    S_PAIR_MUL, S_OFF_ADDR, S_WALK_WB, S_QRY_RD, S_DONE
  } state_t;

  state_t state;

  // Configuration registers and latched request.
  logic [CFG_DATA_W-1:0] block_height;
  logic [CFG_DATA_W-1:0] block_width;
  req_type_t             it_type;
  logic [COLOR_W-1:0]    it_color;
  logic [COLOR_W-1:0]    q_lo;
  logic [COLOR_W-1:0]    q_hi;
  logic [OFFSET_W-1:0]   q_ro;
  logic [OFFSET_W-1:0]   q_co;
  logic                  pix_on;

  // Walk and pair registers.
  logic [BA_W-1:0]     w_addr;
  logic [CW-1:0]       s;
  logic [RW-1:0]       sr;
  logic [CW-1:0]       lo_r;
  logic [CW-1:0]       hi_r;
  logic [RO_W-1:0]     ro_r;
  logic [COL_SPAN-1:0] mask_r;
  logic [PW-1:0]       prod_r;
  logic [OA_W-1:0]     off_addr;
  logic [CLR_W-1:0]    clr_cnt;
  logic                emit_clear;
  logic                res_present;
  logic                res_new;
  logic                rsp_valid;
  logic                out_present;
  logic                out_new;

  // Memories.
  logic [MAX_GRID_COLS-1:0] basic_mem [BASIC_DEPTH];
  logic [COL_SPAN-1:0]      off_mem   [OFF_DEPTH];
  logic [MAX_GRID_COLS-1:0] basic_rdata;
  logic [COL_SPAN-1:0]      off_rdata;

  // Handshakes.
  assign req.ready           = (state == S_IDLE);
  assign cfg.ready           = 1'b1;
  assign rsp.valid           = rsp_valid;
  assign rsp.feature_present = out_present;
  assign rsp.new_basic       = out_new;

  // Effective block sizes saturate at the storage limit.
  logic [DIV_W-1:0] eff_bh;
  logic [DIV_W-1:0] eff_bw;
  assign eff_bh = (DIV_W'(block_height) < DIV_W'(MIN_BH)) ? DIV_W'(MIN_BH)
                                                          : DIV_W'(block_height);
  assign eff_bw = (DIV_W'(block_width) < DIV_W'(MIN_BW)) ? DIV_W'(MIN_BW)
                                                         : DIV_W'(block_width);

  // Grid divider: block row, block column, grid rows - 1, grid columns - 1.
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_dividend [4];
  logic [DIV_W-1:0] div_divisor  [4];
  logic [QW-1:0]    div_quot     [4];
  logic             row_on;
  logic             col_on;

  assign row_on    = DIV_W'(req.pixel_row) < DIV_W'(SCREEN_ROWS);
  assign col_on    = DIV_W'(req.pixel_col) < DIV_W'(SCREEN_COLS);
  assign div_start = req.valid && req.ready &&
                     (req.req_type == REQ_PIXEL || req.req_type == REQ_QUERY);

  always_comb begin
    div_dividend[0] = row_on ? DIV_W'(req.pixel_row) : '0;
    div_dividend[1] = col_on ? DIV_W'(req.pixel_col) : '0;
    div_dividend[2] = DIV_W'(SCREEN_ROWS - 1);
    div_dividend[3] = DIV_W'(SCREEN_COLS - 1);
    div_divisor[0]  = eff_bh;
    div_divisor[1]  = eff_bw;
    div_divisor[2]  = eff_bh;
    div_divisor[3]  = eff_bw;
  end

  bcpof_grid_div #(.QW(QW)) u_grid_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .done     (div_done)
  );

  logic [QW-1:0] blk_r;
  logic [QW-1:0] blk_k;
  logic [QW-1:0] gr_m1;
  logic [QW-1:0] gc_m1;
  assign blk_r = div_quot[0];
  assign blk_k = div_quot[1];
  assign gr_m1 = div_quot[2];
  assign gc_m1 = div_quot[3];

  // Request checks after division.
  logic [CW-1:0]   color_c;
  logic            pix_ok;
  logic            qry_ok;
  logic [BA_W-1:0] pix_addr;
  logic            basic_hit;

  assign color_c  = CW'(it_color);
  assign pix_ok   = pix_on && (9'(it_color) < 9'(COLORS));
  assign qry_ok   = (q_lo <= q_hi) && (9'(q_hi) < 9'(COLORS)) &&
                    (EW'(q_ro) <= EW'({gr_m1, 1'b0})) &&
                    (EW'(q_co) <= EW'({gc_m1, 1'b0})) &&
                    (EW'(q_ro) < EW'(ROW_SPAN)) && (EW'(q_co) < EW'(COL_SPAN));
  assign pix_addr = BA_W'(color_c) * BA_W'(MAX_GRID_ROWS) + BA_W'(blk_r);
  assign basic_hit = basic_rdata[KW'(blk_k)];

  // Pairing of the stored word at (s, sr) with the new feature.
  logic                   lt;
  logic                   gt;
  logic                   eq_row;
  logic                   use_f;
  logic                   use_r;
  logic signed [DW-1:0]   sr_s;
  logic signed [DW-1:0]   r_s;
  logic signed [DW-1:0]   k_s;
  logic signed [DW-1:0]   grm_s;
  logic signed [DW-1:0]   gcm_s;
  logic signed [DW-1:0]   ro_sel;
  logic                   ro_ok;
  logic [COL_SPAN-1:0]    mask_c;
  logic signed [DW-1:0]   co_s;
  logic signed [DW-1:0]   skf;
  logic signed [DW-1:0]   skr;
  logic                   hit_f;
  logic                   hit_r;

  always_comb begin
    lt     = s < color_c;
    gt     = s > color_c;
    eq_row = !lt && !gt && (QW'(sr) == blk_r);
    use_f  = lt || (!gt && (QW'(sr) <= blk_r));
    use_r  = gt || (!lt && (QW'(sr) >= blk_r));
    sr_s   = $signed(DW'(sr));
    r_s    = $signed(DW'(blk_r));
    k_s    = $signed(DW'(blk_k));
    grm_s  = $signed(DW'(gr_m1));
    gcm_s  = $signed(DW'(gc_m1));
    ro_sel = use_f ? (sr_s - r_s + grm_s) : (r_s - sr_s + grm_s);
    ro_ok  = (ro_sel >= 0) && (ro_sel < $signed(DW'(ROW_SPAN)));
    // Each column offset takes one stored column, from either direction.
    // Within the same color and block row, columns left of the new block
    // pair forward and the rest pair in reverse.
    for (int co = 0; co < COL_SPAN; co++) begin
      co_s  = $signed(DW'(co));
      skf   = co_s - gcm_s + k_s;
      skr   = k_s + gcm_s - co_s;
      hit_f = use_f && (!eq_row || (co_s < gcm_s)) &&
              (skf >= 0) && (skf < $signed(DW'(MAX_GRID_COLS))) &&
              basic_rdata[KW'(skf)];
      hit_r = use_r && (!eq_row || (co_s <= gcm_s)) &&
              (skr >= 0) && (skr < $signed(DW'(MAX_GRID_COLS))) &&
              basic_rdata[KW'(skr)];
      mask_c[co] = hit_f || hit_r;
    end
  end

  // Walk position.
  logic            walk_last;
  logic            sr_last;
  logic [BA_W-1:0] w_addr_next;
  logic [CW-1:0]   s_next;
  logic [RW-1:0]   sr_next;

  assign walk_last   = (w_addr == BA_W'(BASIC_DEPTH - 1));
  assign sr_last     = (sr == RW'(MAX_GRID_ROWS - 1));
  assign w_addr_next = w_addr + BA_W'(1);
  assign s_next      = sr_last ? s + CW'(1) : s;
  assign sr_next     = sr_last ? '0 : sr + RW'(1);

  // Offset memory address of the current pair and row offset.
  logic [PI_W-1:0] pidx;
  logic [OA_W-1:0] off_calc;
  assign pidx     = PI_W'(prod_r >> 1) + PI_W'(hi_r) - PI_W'(lo_r);
  assign off_calc = OA_W'(pidx) * OA_W'(ROW_SPAN) + OA_W'(ro_r);

  // Memory port selection.
  logic                     clearing_basic;
  logic                     clr_last;
  logic [BA_W-1:0]          basic_raddr;
  logic                     basic_we;
  logic [BA_W-1:0]          basic_waddr;
  logic [MAX_GRID_COLS-1:0] basic_wdata;
  logic                     off_we;
  logic [OA_W-1:0]          off_waddr;
  logic [COL_SPAN-1:0]      off_wdata;
  logic [OA_W-1:0]          off_raddr;

  assign clearing_basic = ({1'b0, clr_cnt} < (CLR_W + 1)'(BASIC_DEPTH));
  assign clr_last       = (clr_cnt == CLR_W'(CLR_DEPTH - 1));

  always_comb begin
    basic_raddr = (state == S_PIX_RD) ? pix_addr : w_addr;
    basic_we    = (state == S_CLEAR && clearing_basic) ||
                  (state == S_PIX_CHK && !basic_hit);
    basic_waddr = (state == S_CLEAR) ? BA_W'(clr_cnt) : pix_addr;
    basic_wdata = (state == S_CLEAR) ? '0
                  : (basic_rdata | (MAX_GRID_COLS'(1) << KW'(blk_k)));
    off_raddr   = off_calc;
    off_we      = (state == S_CLEAR &&
                   ({1'b0, clr_cnt} < (CLR_W + 1)'(OFF_DEPTH))) ||
                  (state == S_WALK_WB);
    off_waddr   = (state == S_CLEAR) ? OA_W'(clr_cnt) : off_addr;
    off_wdata   = (state == S_CLEAR) ? '0 : (off_rdata | mask_r);
  end

  // Basic presence memory: one word per color and block row.
  always_ff @(posedge clk) begin
    if (basic_we) begin
      basic_mem[basic_waddr] <= basic_wdata;
    end
    basic_rdata <= basic_mem[basic_raddr];
  end

  // Offset presence memory: one word per color pair and row offset.
  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[off_waddr] <= off_wdata;
    end
    off_rdata <= off_mem[off_raddr];
  end

  // Sequencer, configuration registers and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      emit_clear   <= 1'b0;
      rsp_valid    <= 1'b0;
      block_height <= BLOCK_HEIGHT_RESET;
      block_width  <= BLOCK_WIDTH_RESET;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_BLOCK_HEIGHT: block_height <= cfg.data;
          REG_BLOCK_WIDTH:  block_width  <= cfg.data;
          default: ;
        endcase
      end

      // The done step reloads the response register itself.
      if (rsp_valid && rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + CLR_W'(1);
          if (clr_last) begin
            state <= emit_clear ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            it_type     <= req_type_t'(req.req_type);
            it_color    <= req.pixel_color;
            q_lo        <= req.query_color_low;
            q_hi        <= req.query_color_high;
            q_ro        <= req.row_offset;
            q_co        <= req.col_offset;
            pix_on      <= row_on && col_on;
            res_present <= 1'b0;
            res_new     <= 1'b0;
            case (req_type_t'(req.req_type))
              REQ_CLEAR: begin
                clr_cnt    <= '0;
                emit_clear <= 1'b1;
                state      <= S_CLEAR;
              end
              REQ_PIXEL, REQ_QUERY: state <= S_DIV;
              default: state <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (it_type == REQ_PIXEL) begin
              state <= pix_ok ? S_PIX_RD : S_DONE;
            end else if (qry_ok) begin
              lo_r  <= CW'(q_lo);
              hi_r  <= CW'(q_hi);
              ro_r  <= RO_W'(q_ro);
              state <= S_PAIR_MUL;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_PIX_RD: begin
          state <= S_PIX_CHK;
        end
        S_PIX_CHK: begin
          if (basic_hit) begin
            state <= S_DONE;
          end else begin
            res_new <= 1'b1;
            w_addr  <= '0;
            s       <= '0;
            sr      <= '0;
            state   <= S_WALK_RD;
          end
        end
        S_WALK_RD: begin
          state <= S_WALK_CALC;
        end
        S_WALK_CALC: begin
          if (ro_ok && (|mask_c)) begin
            lo_r   <= lt ? s : color_c;
            hi_r   <= lt ? color_c : s;
            ro_r   <= RO_W'(ro_sel);
            mask_r <= mask_c;
            state  <= S_PAIR_MUL;
          end else if (walk_last) begin
            state <= S_DONE;
          end else begin
            w_addr <= w_addr_next;
            s      <= s_next;
            sr     <= sr_next;
            state  <= S_WALK_RD;
          end
        end
        S_PAIR_MUL: begin
          // lo * (2*COLORS + 1 - lo) is twice the base index of the pair row.
          prod_r <= PW'(lo_r) * PW'(PM_W'(2 * COLORS + 1) - PM_W'(lo_r));
          state  <= S_OFF_ADDR;
        end
        S_OFF_ADDR: begin
          off_addr <= off_calc;
          state    <= (it_type == REQ_QUERY) ? S_QRY_RD : S_WALK_WB;
        end
        S_WALK_WB: begin
          if (walk_last) begin
            state <= S_DONE;
          end else begin
            w_addr <= w_addr_next;
            s      <= s_next;
            sr     <= sr_next;
            state  <= S_WALK_RD;
          end
        end
        S_QRY_RD: begin
          res_present <= off_rdata[CO_W'(q_co)];
          state       <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid   <= 1'b1;
            out_present <= res_present;
            out_new     <= res_new;
            emit_clear  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A response never reports a query hit and a new pixel feature together.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.feature_present && rsp.new_basic))
    else $error("response carries both a query hit and a new feature");

  // Both memories are written in one cycle only by the clearing sweep.
  assert property (@(posedge clk) disable iff (rst)
    (basic_we && off_we) |-> (state == S_CLEAR))
    else $error("basic and offset memory written together outside clear");

  // Offset writes stay inside the memory.
  assert property (@(posedge clk) disable iff (rst)
    off_we |-> ({1'b0, off_waddr} < (OA_W + 1)'(OFF_DEPTH)))
    else $error("offset memory write out of range");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("grid divider finished outside the divide step");

  // A new feature always follows a basic memory miss.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PIX_CHK && basic_hit) |=> !res_new)
    else $error("new feature reported for a block color already present");
`endif

endmodule
